// File: sv/tts_pkg.sv
`default_nettype none

package tts_pkg;

    // Pixel and result field widths
    localparam int unsigned CHANNEL_W     = 8;
    localparam int unsigned PIXEL_W       = 4 * CHANNEL_W;
    localparam int unsigned TEXEL_INDEX_W = 20;
    localparam int unsigned TEX_SIDE_W    = 11;
    localparam int unsigned OUT_FIELDS_W  = TEXEL_INDEX_W + PIXEL_W + 2 * TEX_SIDE_W;
    localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // Tile geometry: 8x8 texels, six interleaved offset bits
    localparam int unsigned TILE_SHIFT    = 3;
    localparam int unsigned TILE_OFFS_W   = 2 * TILE_SHIFT;

    // Configuration port
    localparam int unsigned CFG_INDEX_W   = 8;
    localparam int unsigned CFG_DATA_W    = 11;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_IMAGE_WIDTH  = 8'd0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 8'd1;

    // Reorder R,G,B,A (red lowest) into A,B,G,R (alpha lowest)
    function automatic logic [PIXEL_W-1:0] swap_bytes(input logic [PIXEL_W-1:0] rgba);
        return {rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24]};
    endfunction

endpackage

`default_nettype wire

// File: sv/tts_cfg.sv
`default_nettype none

module tts_cfg #(
    parameter int unsigned MAX_SIDE         = 1024,
    parameter int unsigned MIN_TEXTURE_SIDE = 64,
    parameter int unsigned SIDE_W           = 11,
    parameter int unsigned PAD_W            = 11
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [tts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tts_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                restart,
    output logic [SIDE_W-1:0]                   eff_w,
    output logic [SIDE_W-1:0]                   eff_h,
    output logic [PAD_W-1:0]                    pad_w,
    output logic [PAD_W-1:0]                    pad_h
);
    import tts_pkg::*;

    localparam int unsigned CW = (SIDE_W > CFG_DATA_W) ? SIDE_W : CFG_DATA_W;

    // Clamp a register value to 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_DATA_W-1:0] raw);
        logic [CW-1:0] s;
        s = CW'(raw);
        if (s == '0)
            s = CW'(1);
        if (s > CW'(MAX_SIDE))
            s = CW'(MAX_SIDE);
        return SIDE_W'(s);
    endfunction

    // Next power of two not below the side, at least MIN_TEXTURE_SIDE
    function automatic logic [PAD_W-1:0] pad_side(input logic [SIDE_W-1:0] side);
        logic [PAD_W-1:0] ge;
        logic [PAD_W-1:0] p;
        for (int i = 0; i < PAD_W; i++)
            ge[i] = (PAD_W'(side) <= (PAD_W'(1) << i));
        p = ge & ~(ge << 1);
        if (p < PAD_W'(MIN_TEXTURE_SIDE))
            p = PAD_W'(MIN_TEXTURE_SIDE);
        return p;
    endfunction

    logic                 wr_w;
    logic                 wr_h;
    logic [SIDE_W-1:0]    new_eff;
    logic [SIDE_W-1:0]    eff_w_reg;
    logic [SIDE_W-1:0]    eff_h_reg;
    logic [PAD_W-1:0]     pad_w_reg;
    logic [PAD_W-1:0]     pad_h_reg;

    // Decode the register index
    assign wr_w    = cfg_valid && (cfg_index == REG_IMAGE_WIDTH);
    assign wr_h    = cfg_valid && (cfg_index == REG_IMAGE_HEIGHT);
    assign restart = wr_w || wr_h;
    assign new_eff = eff_side(cfg_data);

    // Hold effective and padded sides
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= SIDE_W'(1);
            eff_h_reg <= SIDE_W'(1);
            pad_w_reg <= pad_side(SIDE_W'(1));
            pad_h_reg <= pad_side(SIDE_W'(1));
        end
        else
        begin
            if (wr_w)
            begin
                eff_w_reg <= new_eff;
                pad_w_reg <= pad_side(new_eff);
            end
            if (wr_h)
            begin
                eff_h_reg <= new_eff;
                pad_h_reg <= pad_side(new_eff);
            end
        end
    end

    assign eff_w = eff_w_reg;
    assign eff_h = eff_h_reg;
    assign pad_w = pad_w_reg;
    assign pad_h = pad_h_reg;

endmodule

`default_nettype wire

// File: sv/tts_scan.sv
`default_nettype none

module tts_scan #(
    parameter int unsigned CNT_W  = 10,
    parameter int unsigned SIDE_W = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              restart,
    input  wire logic [SIDE_W-1:0] eff_w,
    input  wire logic [SIDE_W-1:0] eff_h,
    output logic [CNT_W-1:0]       x,
    output logic [CNT_W-1:0]       y,
    output logic                   last
);
    logic [CNT_W-1:0] x_reg;
    logic [CNT_W-1:0] y_reg;
    logic [CNT_W-1:0] x_next;
    logic [CNT_W-1:0] y_next;
    logic             col_end;
    logic             row_end;

    // Flag end of row and end of image
    assign col_end = (SIDE_W'(x_reg) + SIDE_W'(1)) >= eff_w;
    assign row_end = (SIDE_W'(y_reg) + SIDE_W'(1)) >= eff_h;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (restart)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (advance)
        begin
            if (col_end)
            begin
                x_next = '0;
                y_next = row_end ? '0 : y_reg + CNT_W'(1);
            end
            else
            begin
                x_next = x_reg + CNT_W'(1);
            end
        end
    end

    // Advance the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign last = col_end && row_end;

endmodule

`default_nettype wire

// File: sv/tts_map.sv
`default_nettype none

module tts_map #(
    parameter int unsigned CNT_W = 10,
    parameter int unsigned PAD_W = 11
) (
    input  wire logic [CNT_W-1:0]               x,
    input  wire logic [CNT_W-1:0]               y,
    input  wire logic [PAD_W-1:0]               pad_w,
    output logic [tts_pkg::TEXEL_INDEX_W-1:0]   texel_index
);
    import tts_pkg::*;

    localparam int unsigned TY_W   = CNT_W - TILE_SHIFT;
    localparam int unsigned TW_W   = PAD_W - TILE_SHIFT;
    localparam int unsigned TILE_W = TY_W + TW_W + 1;
    localparam int unsigned RAW_W  = TILE_W + TILE_OFFS_W;
    localparam int unsigned IDX_W  = (RAW_W > TEXEL_INDEX_W) ? RAW_W : TEXEL_INDEX_W;

    logic [TILE_OFFS_W-1:0] offs;
    logic [TILE_W-1:0]      tile;
    logic [IDX_W-1:0]       idx;

    // Interleave x and y inside the 8x8 tile, x in the lowest bit
    assign offs = {y[2], x[2], y[1], x[1], y[0], x[0]};

    // Tiles run row-major over the padded width
    assign tile = TILE_W'(y[CNT_W-1:TILE_SHIFT]) * TILE_W'(pad_w[PAD_W-1:TILE_SHIFT])
                + TILE_W'(x[CNT_W-1:TILE_SHIFT]);

    assign idx         = IDX_W'({tile, offs});
    assign texel_index = idx[TEXEL_INDEX_W-1:0];

endmodule

`default_nettype wire

// File: sv/texture_tile_swizzle.sv
// Texture tile swizzle: maps a raster stream of RGBA8 pixels onto a texture
// stored as 8x8 tiles whose texels follow Morton order.
// Channels:
//   cfg     - register writes (index 0 image width, index 1 image height);
//             cfg_ready is always high. A write to either restarts the raster at 0,0.
//   s_axis  - one pixel per word, red in the lowest byte, row-major order.
//   m_axis  - one result word per pixel: texel index, A,B,G,R word and the
//             padded texture sides; tlast marks the final pixel of an image.
// Pipeline: a taken pixel enters the input register, then the result register
// with the address logic between them; the result is valid from there.
// Throughput: one pixel per cycle while m_axis_tready stays high.
// Stalls: when the receiver holds tready low the result register keeps its
// word and the input register takes one more pixel; s_axis_tready then drops
// until the result drains.
// Reset: both sides read as 1 (padded to the minimum texture side), the
// raster position returns to 0,0 and both channels are emptied.
`default_nettype none

module texture_tile_swizzle #(
    parameter int unsigned MAX_SIDE         = 1024,
    parameter int unsigned MIN_TEXTURE_SIDE = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // red, green, blue, alpha
    input  wire logic [tts_pkg::PIXEL_W-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // texel_index, texel_word, texture_width, texture_height, zero fill
    output logic [tts_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast
);
    import tts_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_SIDE);
    localparam int unsigned SIDE_W = CNT_W + 1;
    localparam int unsigned BIG    = (MAX_SIDE > MIN_TEXTURE_SIDE) ? MAX_SIDE
                                                                    : MIN_TEXTURE_SIDE;
    localparam int unsigned PAD_W  = $clog2(BIG) + 1;
    localparam int unsigned WIDE_W = (PAD_W > TEX_SIDE_W) ? PAD_W : TEX_SIDE_W;

    logic                      restart;
    logic [SIDE_W-1:0]         eff_w;
    logic [SIDE_W-1:0]         eff_h;
    logic [PAD_W-1:0]          pad_w;
    logic [PAD_W-1:0]          pad_h;
    logic [WIDE_W-1:0]         pad_w_ext;
    logic [WIDE_W-1:0]         pad_h_ext;
    logic [CNT_W-1:0]          scan_x;
    logic [CNT_W-1:0]          scan_y;
    logic                      scan_last;
    logic                      in_take;
    logic                      s1_load;

    logic                      s1_valid_reg;
    logic [PIXEL_W-1:0]        s1_pixel_reg;
    logic [CNT_W-1:0]          s1_x_reg;
    logic [CNT_W-1:0]          s1_y_reg;
    logic                      s1_last_reg;

    logic [TEXEL_INDEX_W-1:0]  map_index;
    logic                      out_valid_reg;
    logic [TEXEL_INDEX_W-1:0]  out_index_reg;
    logic [PIXEL_W-1:0]        out_word_reg;
    logic [TEX_SIDE_W-1:0]     out_tw_reg;
    logic [TEX_SIDE_W-1:0]     out_th_reg;
    logic                      out_last_reg;

    tts_cfg #(
        .MAX_SIDE         (MAX_SIDE),
        .MIN_TEXTURE_SIDE (MIN_TEXTURE_SIDE),
        .SIDE_W           (SIDE_W),
        .PAD_W            (PAD_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (restart),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .pad_w     (pad_w),
        .pad_h     (pad_h)
    );

    assign cfg_ready = 1'b1;

    tts_scan #(
        .CNT_W  (CNT_W),
        .SIDE_W (SIDE_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_take),
        .restart (restart),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .x       (scan_x),
        .y       (scan_y),
        .last    (scan_last)
    );

    // Move a word forward when the next stage is empty or draining
    assign s1_load       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register: pixel with its raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pixel_reg <= s_axis_tdata;
            s1_x_reg     <= scan_x;
            s1_y_reg     <= scan_y;
            s1_last_reg  <= scan_last;
        end
    end

    tts_map #(
        .CNT_W (CNT_W),
        .PAD_W (PAD_W)
    ) u_map (
        .x           (s1_x_reg),
        .y           (s1_y_reg),
        .pad_w       (pad_w),
        .texel_index (map_index)
    );

    assign pad_w_ext = WIDE_W'(pad_w);
    assign pad_h_ext = WIDE_W'(pad_h);

    // Result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_axis_tready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            out_index_reg <= map_index;
            out_word_reg  <= swap_bytes(s1_pixel_reg);
            out_tw_reg    <= pad_w_ext[TEX_SIDE_W-1:0];
            out_th_reg    <= pad_h_ext[TEX_SIDE_W-1:0];
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_th_reg, out_tw_reg,
                            out_word_reg, out_index_reg};
    assign m_axis_tlast  = out_valid_reg && out_last_reg;

    // Raster position stays inside the image
    assert property (@(posedge clk) disable iff (!rst_n)
        (SIDE_W'(scan_x) < eff_w) && (SIDE_W'(scan_y) < eff_h))
    else $error("raster position outside the image");

    // Taking the final pixel sends the raster back to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && scan_last |=> (scan_x == '0) && (scan_y == '0))
    else $error("raster did not wrap after the final pixel");

    // An empty input register always takes a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
    import tts_pkg::*;

    localparam int unsigned MAX_SIDE         = 1024;
    localparam int unsigned MIN_TEXTURE_SIDE = 64;
    localparam int unsigned STALL_LIMIT      = 2000;
    localparam int unsigned ITEM_TARGET      = 1500;
    localparam int unsigned PHASE_CAP        = 300;
    localparam int unsigned REPORT_LIMIT     = 10;
    localparam int unsigned DRAIN_CYCLES     = 4;
    localparam cfg_index_t  FIRST_UNUSED_REG = REG_IMAGE_HEIGHT + 8'd1;
    localparam cfg_index_t  LAST_UNUSED_REG  = '1;

    // Source pixel as carried on s_axis_tdata, red in the lowest byte
    typedef struct packed {
        logic [CHANNEL_W-1:0] alpha;
        logic [CHANNEL_W-1:0] blue;
        logic [CHANNEL_W-1:0] green;
        logic [CHANNEL_W-1:0] red;
    } pixel_t;

    // Result word with tlast on top, texel index in the lowest bits
    typedef struct packed {
        logic                     last_pixel;
        logic [OUT_PAD_W-1:0]     zero_fill;
        logic [TEX_SIDE_W-1:0]    tex_height;
        logic [TEX_SIDE_W-1:0]    tex_width;
        logic [PIXEL_W-1:0]       texel_word;
        logic [TEXEL_INDEX_W-1:0] texel_index;
    } texel_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // Predictor state: register copies and raster position
    logic [CFG_DATA_W-1:0]  width_reg  = 11'd1;
    logic [CFG_DATA_W-1:0]  height_reg = 11'd1;
    int unsigned            column_pos = 0;
    int unsigned            row_pos    = 0;

    logic [PIXEL_W-1:0]     pixel_queue[$];
    texel_t                 awaited_texels[$];
    texel_t                 texel_seen;
    texel_t                 texel_due;

    int unsigned            failures     = 0;
    int unsigned            results_seen = 0;
    int unsigned            idle_cycles  = 0;
    int unsigned            burst_left   = 0;
    int unsigned            gap_left     = 0;
    int unsigned            hold_left    = 0;
    int unsigned            mode_left    = 0;
    int unsigned            stall_mode   = 0;
    bit                     long_hold_done = 1'b0;

    texture_tile_swizzle #(
        .MAX_SIDE         (MAX_SIDE),
        .MIN_TEXTURE_SIDE (MIN_TEXTURE_SIDE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clamp a side register to the range the block counts in
    function automatic int unsigned effective_side(input logic [CFG_DATA_W-1:0] side_reg);
        if (side_reg == '0)
            return 1;
        if (side_reg > MAX_SIDE)
            return MAX_SIDE;
        return 32'(side_reg);
    endfunction

    // Next power of two, never below the minimum texture side
    function automatic int unsigned padded_side(input int unsigned side);
        int unsigned p;
        p = 1;
        while (p < side)
            p = p << 1;
        return (p < MIN_TEXTURE_SIDE) ? MIN_TEXTURE_SIDE : p;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] extreme_side(input int unsigned pick);
        case (pick)
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd63;
            3:       return 11'd64;
            4:       return 11'd65;
            5:       return 11'd1023;
            6:       return 11'd1024;
            7:       return 11'd1025;
            default: return 11'd2047;
        endcase
    endfunction

    // Work out the tiled texel for one taken pixel and advance the raster
    task automatic swizzle_pixel(input pixel_t px);
        texel_t          t;
        int unsigned     w, h, tw, th, tile;
        logic [9:0]      x, y;
        logic [5:0]      inner;
        w = effective_side(width_reg);
        h = effective_side(height_reg);
        tw = padded_side(w);
        th = padded_side(h);
        x = 10'(column_pos);
        y = 10'(row_pos);
        // Morton offset inside the 8x8 tile, x bit lowest
        inner = {y[2], x[2], y[1], x[1], y[0], x[0]};
        tile = (row_pos >> TILE_SHIFT) * (tw >> TILE_SHIFT) + (column_pos >> TILE_SHIFT);
        t.texel_index = TEXEL_INDEX_W'((tile << TILE_OFFS_W) + inner);
        t.texel_word  = {px.red, px.green, px.blue, px.alpha};
        t.tex_width   = TEX_SIDE_W'(tw);
        t.tex_height  = TEX_SIDE_W'(th);
        t.zero_fill   = '0;
        t.last_pixel  = (column_pos + 1 >= w) && (row_pos + 1 >= h);
        awaited_texels.push_back(t);
        if (column_pos + 1 >= w)
        begin
            column_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            column_pos = column_pos + 1;
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_register(input cfg_index_t index, input logic [CFG_DATA_W-1:0] reg_value);
        @(posedge clk);
        cfg_index <= index;
        cfg_data  <= reg_value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (index)
            REG_IMAGE_WIDTH:
            begin
                width_reg  = reg_value;
                column_pos = 0;
                row_pos    = 0;
            end
            REG_IMAGE_HEIGHT:
            begin
                height_reg = reg_value;
                column_pos = 0;
                row_pos    = 0;
            end
            default: ;
        endcase
    endtask

    // Hold until every pixel is taken and every texel returned, then let it settle;
    // sample between edges so the sender and receiver have finished their updates
    task automatic wait_idle();
        @(negedge clk);
        while (pixel_queue.size() != 0 || awaited_texels.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_pixels(input int unsigned count);
        repeat (count)
        begin
            case ($urandom_range(0, 7))
                0:       pixel_queue.push_back('0);
                1:       pixel_queue.push_back('1);
                default: pixel_queue.push_back($urandom);
            endcase
        end
    endtask

    // Stimulus: directed phases first, then random image shapes
    initial
    begin
        int unsigned item_total;
        int unsigned image_pixels;
        int unsigned count;
        logic [CFG_DATA_W-1:0] width_value, height_value;
        item_total = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset shape 1x1: every pixel is the last one
        pixel_queue.push_back(32'h0000_0000);
        pixel_queue.push_back(32'hFFFF_FFFF);
        pixel_queue.push_back(32'h55AA_33CC);
        pixel_queue.push_back(32'hAA55_CC33);
        pixel_queue.push_back(32'h0403_0201);
        wait_idle();

        // Zero sides count as one
        write_register(REG_IMAGE_WIDTH, 11'd0);
        write_register(REG_IMAGE_HEIGHT, 11'd0);
        load_pixels(2);
        wait_idle();

        // Oversized sides clamp; a write to an unused index leaves the raster alone
        write_register(REG_IMAGE_WIDTH, 11'd2047);
        write_register(REG_IMAGE_HEIGHT, 11'd1025);
        load_pixels(3);
        wait_idle();
        write_register(FIRST_UNUSED_REG, '1);
        write_register(LAST_UNUSED_REG, '0);
        load_pixels(2);
        wait_idle();

        // Padding just above and below a power of two
        write_register(REG_IMAGE_WIDTH, 11'd65);
        write_register(REG_IMAGE_HEIGHT, 11'd63);
        load_pixels(3);
        wait_idle();

        // Small image run past its end to show the wrap
        write_register(REG_IMAGE_WIDTH, 11'd3);
        write_register(REG_IMAGE_HEIGHT, 11'd2);
        load_pixels(7);
        wait_idle();

        // Full row at the widest side, through the last pixel and the wrap
        write_register(REG_IMAGE_HEIGHT, 11'd1);
        write_register(REG_IMAGE_WIDTH, 11'd1024);
        load_pixels(MAX_SIDE + 2);
        item_total = MAX_SIDE + 2;
        wait_idle();

        while (item_total < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    width_value  = extreme_side($urandom_range(0, 8));
                    height_value = CFG_DATA_W'($urandom_range(1, 4));
                end
                1:
                begin
                    width_value  = CFG_DATA_W'($urandom_range(1, 3));
                    height_value = extreme_side($urandom_range(0, 8));
                end
                default:
                begin
                    width_value  = CFG_DATA_W'($urandom_range(1, 24));
                    height_value = CFG_DATA_W'($urandom_range(1, 12));
                end
            endcase
            if ($urandom_range(0, 5) == 0)
                write_register(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                               CFG_DATA_W'($urandom));
            case ($urandom_range(0, 5))
                0:       write_register(REG_IMAGE_WIDTH, width_value);
                1:       write_register(REG_IMAGE_HEIGHT, height_value);
                2:
                begin
                    write_register(REG_IMAGE_HEIGHT, height_value);
                    write_register(REG_IMAGE_WIDTH, width_value);
                end
                default:
                begin
                    write_register(REG_IMAGE_WIDTH, width_value);
                    write_register(REG_IMAGE_HEIGHT, height_value);
                end
            endcase
            image_pixels = effective_side(width_reg) * effective_side(height_reg);
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, image_pixels);
            else
                count = image_pixels + $urandom_range(0, image_pixels);
            if (count > PHASE_CAP)
                count = PHASE_CAP;
            load_pixels(count);
            item_total = item_total + count;
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (failures == 0 && awaited_texels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Pixel sender: bursts of random length with random gaps between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                swizzle_pixel(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    s_axis_tdata  <= pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Texel receiver: check each word, then pick the next tready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                texel_seen   = {m_axis_tlast, m_axis_tdata};
                results_seen = results_seen + 1;
                if (awaited_texels.size() == 0)
                begin
                    failures = failures + 1;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected texel word: index %h word %h last %b",
                                 texel_seen.texel_index, texel_seen.texel_word,
                                 texel_seen.last_pixel);
                end
                else
                begin
                    texel_due = awaited_texels.pop_front();
                    if (texel_seen !== texel_due)
                    begin
                        failures = failures + 1;
                        if (failures <= REPORT_LIMIT)
                        begin
                            $display("texel mismatch: expected index %h word %h tex %0dx%0d last %b fill %h",
                                     texel_due.texel_index, texel_due.texel_word,
                                     texel_due.tex_width, texel_due.tex_height,
                                     texel_due.last_pixel, texel_due.zero_fill);
                            $display("                got      index %h word %h tex %0dx%0d last %b fill %h",
                                     texel_seen.texel_index, texel_seen.texel_word,
                                     texel_seen.tex_width, texel_seen.tex_height,
                                     texel_seen.last_pixel, texel_seen.zero_fill);
                        end
                    end
                end
            end

            // Long hold-off once the sender has plenty queued, so the input backs up
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 50 && pixel_queue.size() > 40)
            begin
                long_hold_done = 1'b1;
                hold_left = 300;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 300);
                    if ($urandom_range(0, 9) == 0)
                        hold_left = $urandom_range(50, 200);
                end
                else
                    mode_left = mode_left - 1;
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
